>>> rtl/snfcs_pkg.sv
// Shared types and constants for the SPI NOR flash command sequencer.
// No dependencies; imported by the front, queue, back and top modules.
package snfcs_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_SECTOR = 3'd2;
  localparam logic [2:0] KIND_BLOCK  = 3'd3;
  localparam logic [2:0] KIND_WDATA  = 3'd4;
  localparam logic [2:0] KIND_RX     = 3'd5;

  localparam logic [2:0] EV_SEND    = 3'd0;
  localparam logic [2:0] EV_RELEASE = 3'd1;
  localparam logic [2:0] EV_READ    = 3'd2;
  localparam logic [2:0] EV_NEED    = 3'd3;
  localparam logic [2:0] EV_DONE    = 3'd4;

  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_RDSR   = 8'h05;
  localparam logic [7:0] OP_READ   = 8'h03;
  localparam logic [7:0] OP_PP     = 8'h02;
  localparam logic [7:0] OP_SE     = 8'h20;
  localparam logic [7:0] OP_BE     = 8'hD8;
  localparam logic [7:0] DUMMY     = 8'hFF;

  // Up to three results caused by one input beat.
  typedef struct packed {
    logic [1:0]            cnt;
    logic [2:0][2:0]       ev;
    logic [2:0][7:0]       val;
  } res_bundle_t;

  function automatic res_bundle_t add_res(res_bundle_t b, logic [2:0] e, logic [7:0] v);
    res_bundle_t r;
    r = b;
    if (b.cnt != 2'd3) begin
      r.ev[b.cnt]  = e;
      r.val[b.cnt] = v;
      r.cnt        = b.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

>>> rtl/snfcs_front.sv
// Front end: accepts input beats, runs the command state machine and
// builds one result bundle per beat. Depends on snfcs_pkg.
module snfcs_front #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_acc,
  input  logic [2:0]           kind,
  input  logic [23:0]          address,
  input  logic [7:0]           block_index,
  input  logic [15:0]          length,
  input  logic [7:0]           data_byte,
  output logic                 push,
  output snfcs_pkg::res_bundle_t bundle
);
  import snfcs_pkg::*;

  localparam int unsigned AW = $clog2(PAGE_BYTES);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] PAGE_C = CW'(PAGE_BYTES);

  typedef enum logic [3:0] {
    PH_IDLE, PH_WREN, PH_HDR, PH_NEED, PH_DATA,
    PH_PCMD_PRE, PH_POLL_PRE, PH_PCMD, PH_POLL, PH_READ
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [15:0] left_r, left_nxt;
  logic [CW-1:0] chunk_r, chunk_nxt;
  logic [1:0]  hidx_r, hidx_nxt;
  res_bundle_t b;

  function automatic logic [7:0] hdr_byte(logic [1:0] op, logic [23:0] a, logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: begin
        unique case (op)
          2'd0: r = OP_READ;
          2'd1: r = OP_PP;
          2'd2: r = OP_SE;
          default: r = OP_BE;
        endcase
      end
      2'd1: r = a[23:16];
      2'd2: r = a[15:8];
      default: r = a[7:0];
    endcase
    return r;
  endfunction

  // Bytes up to the next page boundary, capped by what is left.
  function automatic logic [CW-1:0] chunk_len(logic [23:0] a, logic [15:0] bl);
    logic [CW-1:0] room;
    room = PAGE_C - CW'(a[AW-1:0]);
    return (bl < 16'(room)) ? CW'(bl) : room;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    chunk_nxt = chunk_r;
    hidx_nxt  = hidx_r;
    b         = '0;
    if (in_acc) begin
      priority if (kind <= KIND_BLOCK) begin
        if (phase_r == PH_IDLE) begin
          op_nxt    = kind[1:0];
          addr_nxt  = (kind == KIND_BLOCK) ? {block_index, 16'h0000} : address;
          left_nxt  = (kind <= KIND_WRITE) ? length : 16'd0;
          chunk_nxt = '0;
          if (kind == KIND_READ) begin
            hidx_nxt  = 2'd0;
            b         = add_res(b, EV_SEND, hdr_byte(op_nxt, addr_nxt, 2'd0));
            phase_nxt = PH_HDR;
          end else if (kind == KIND_WRITE) begin
            if (length == 16'd0) begin
              b = add_res(b, EV_DONE, 8'h00);
            end else begin
              chunk_nxt = chunk_len(addr_nxt, left_nxt);
              b         = add_res(b, EV_SEND, OP_WREN);
              phase_nxt = PH_WREN;
            end
          end else begin
            b         = add_res(b, EV_SEND, OP_WREN);
            phase_nxt = PH_WREN;
          end
        end
      end else if (kind == KIND_WDATA) begin
        if (phase_r == PH_NEED) begin
          b         = add_res(b, EV_SEND, data_byte);
          phase_nxt = PH_DATA;
        end
      end else if (kind == KIND_RX) begin
        unique case (phase_r)
          PH_WREN: begin
            b = add_res(b, EV_RELEASE, 8'h00);
            if (op_r == 2'd1) begin
              hidx_nxt  = 2'd0;
              b         = add_res(b, EV_SEND, hdr_byte(op_r, addr_r, 2'd0));
              phase_nxt = PH_HDR;
            end else begin
              b         = add_res(b, EV_SEND, OP_RDSR);
              phase_nxt = PH_PCMD_PRE;
            end
          end
          PH_HDR: begin
            if (hidx_r != 2'd3) begin
              hidx_nxt = hidx_r + 2'd1;
              b        = add_res(b, EV_SEND, hdr_byte(op_r, addr_r, hidx_nxt));
            end else if (op_r == 2'd0) begin
              if (left_r == 16'd0) begin
                b         = add_res(b, EV_RELEASE, 8'h00);
                b         = add_res(b, EV_DONE, 8'h00);
                phase_nxt = PH_IDLE;
              end else begin
                b         = add_res(b, EV_SEND, DUMMY);
                phase_nxt = PH_READ;
              end
            end else if (op_r == 2'd1) begin
              b         = add_res(b, EV_NEED, 8'h00);
              phase_nxt = PH_NEED;
            end else begin
              b         = add_res(b, EV_RELEASE, 8'h00);
              b         = add_res(b, EV_SEND, OP_RDSR);
              phase_nxt = PH_PCMD;
            end
          end
          PH_DATA: begin
            addr_nxt = addr_r + 24'd1;
            if (left_r != 16'd0) left_nxt = left_r - 16'd1;
            if (chunk_r != '0) chunk_nxt = chunk_r - CW'(1);
            if (chunk_nxt != '0) begin
              b         = add_res(b, EV_NEED, 8'h00);
              phase_nxt = PH_NEED;
            end else begin
              b         = add_res(b, EV_RELEASE, 8'h00);
              b         = add_res(b, EV_SEND, OP_RDSR);
              phase_nxt = PH_PCMD;
            end
          end
          PH_PCMD_PRE: begin
            b         = add_res(b, EV_SEND, DUMMY);
            phase_nxt = PH_POLL_PRE;
          end
          PH_POLL_PRE: begin
            if (data_byte[0]) begin
              b = add_res(b, EV_SEND, DUMMY);
            end else begin
              b         = add_res(b, EV_RELEASE, 8'h00);
              hidx_nxt  = 2'd0;
              b         = add_res(b, EV_SEND, hdr_byte(op_r, addr_r, 2'd0));
              phase_nxt = PH_HDR;
            end
          end
          PH_PCMD: begin
            b         = add_res(b, EV_SEND, DUMMY);
            phase_nxt = PH_POLL;
          end
          PH_POLL: begin
            if (data_byte[0]) begin
              b = add_res(b, EV_SEND, DUMMY);
            end else if (op_r == 2'd1 && left_r != 16'd0) begin
              b         = add_res(b, EV_RELEASE, 8'h00);
              chunk_nxt = chunk_len(addr_r, left_r);
              b         = add_res(b, EV_SEND, OP_WREN);
              phase_nxt = PH_WREN;
            end else begin
              b         = add_res(b, EV_RELEASE, 8'h00);
              b         = add_res(b, EV_DONE, 8'h00);
              phase_nxt = PH_IDLE;
            end
          end
          PH_READ: begin
            b = add_res(b, EV_READ, data_byte);
            if (left_r != 16'd0) left_nxt = left_r - 16'd1;
            if (left_nxt != 16'd0) begin
              b = add_res(b, EV_SEND, DUMMY);
            end else begin
              b         = add_res(b, EV_RELEASE, 8'h00);
              b         = add_res(b, EV_DONE, 8'h00);
              phase_nxt = PH_IDLE;
            end
          end
          default: ;
        endcase
      end else begin
        // drop unknown kinds
      end
    end
  end

  assign push   = in_acc && (b.cnt != 2'd0);
  assign bundle = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= 2'd0;
      addr_r  <= '0;
      left_r  <= '0;
      chunk_r <= '0;
      hidx_r  <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      chunk_r <= chunk_nxt;
      hidx_r  <= hidx_nxt;
    end
  end

endmodule

>>> rtl/snfcs_queue.sv
// Short bundle queue between front and back ends.
// Depends on snfcs_pkg for the bundle type and depth.
module snfcs_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  snfcs_pkg::res_bundle_t wr_data,
  input  logic                   pop,
  output snfcs_pkg::res_bundle_t rd_data,
  output logic                   empty,
  output logic                   full,
  output logic [snfcs_pkg::QAW:0] count
);
  import snfcs_pkg::*;

  res_bundle_t    mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign rd_data = mem_r[rp_r];
  assign count   = cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QAW'(1);
      if (pop)  rp_r <= rp_r + QAW'(1);
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

>>> rtl/snfcs_back.sv
// Back end: takes bundles from the queue and sends their results one beat
// at a time on the output stream. Depends on snfcs_pkg.
module snfcs_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  snfcs_pkg::res_bundle_t q_data,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,
  output logic [2:0]             out_tuser,
  output logic                   out_tlast
);
  import snfcs_pkg::*;

  res_bundle_t cur_r;
  logic        busy_r;
  logic [1:0]  idx_r;
  logic        fin;

  assign out_tvalid = busy_r;
  assign out_tdata  = cur_r.val[idx_r];
  assign out_tuser  = cur_r.ev[idx_r];
  assign out_tlast  = (idx_r == cur_r.cnt - 2'd1);
  assign fin        = busy_r && out_tready && out_tlast;
  assign q_pop      = !q_empty && (!busy_r || fin);

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (fin) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (busy_r && out_tready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

>>> rtl/spi_nor_flash_command_sequencer.sv
// Top level of the SPI NOR flash command sequencer: front end, bundle
// queue and back end. Depends on snfcs_pkg, snfcs_front, snfcs_queue, snfcs_back.
//
//  channel | direction | tuser            | tdata
//  in_     | slave     | kind             | address, block_index, length, data_byte
//  out_    | master    | event_res        | byte_value (tlast = last)
//
// An input beat is taken each cycle while the four-entry bundle queue has room;
// its state update is done in that cycle. The output side sends one result
// per cycle while out_tready is high, and holds each bundle until it is all sent.
// Reset is synchronous; the queue and output register start empty.
// PAGE_BYTES must be a power of two.
module spi_nor_flash_command_sequencer #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // address[23:0], block_index[31:24], length[47:32], data_byte[55:48]
  input  logic [2:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // byte_value
  output logic [2:0]  out_tuser,  // event_res
  output logic        out_tlast
);
  import snfcs_pkg::*;

  logic        in_acc, push, pop, q_empty, q_full;
  logic [QAW:0] q_count;
  res_bundle_t bundle, q_data;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  snfcs_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_acc(in_acc),
    .kind(in_tuser), .address(in_tdata[23:0]), .block_index(in_tdata[31:24]),
    .length(in_tdata[47:32]), .data_byte(in_tdata[55:48]),
    .push(push), .bundle(bundle)
  );

  snfcs_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_data(bundle), .pop(pop),
    .rd_data(q_data), .empty(q_empty), .full(q_full), .count(q_count)
  );

  snfcs_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data), .q_pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full)) else $error("bundle pushed into full queue");
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> bundle.cnt != 2'd0) else $error("empty bundle pushed");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_count != '0) else $error("pop from empty queue");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid after reset");
`endif

endmodule

>>> test/spi_nor_flash_command_sequencer_tb.sv
// Self-checking bench for the SPI NOR flash command sequencer.
// Drives request/data/SPI-echo beats, predicts every result, compares in order.
// Depends on snfcs_pkg and spi_nor_flash_command_sequencer.
module spi_nor_flash_command_sequencer_tb;
  import snfcs_pkg::*;

  localparam int unsigned PAGE = 256;
  localparam int          CYCLE_LIMIT = 50000;
  localparam int          BEAT_TARGET = 262;
  localparam logic [2:0]  KIND_RSVD6  = 3'd6;
  localparam logic [2:0]  KIND_RSVD7  = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_WREN, S_HDR, S_NEED, S_DATA, S_PCMD_PRE, S_POLL_PRE, S_PCMD, S_POLL, S_READ
  } seq_phase_t;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] val;
    logic       last;
  } flash_res_t;

  typedef struct {
    logic [2:0]  kind;
    logic [23:0] addr;
    logic [7:0]  blk;
    logic [15:0] len;
    logic [7:0]  dat;
    int          n_fixed;   // -1: check against predictor only
    flash_res_t  fixed0;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  always #10 clk = ~clk;

  spi_nor_flash_command_sequencer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // predictor state
  seq_phase_t  ph;
  logic [1:0]  op;
  logic [23:0] cur_addr;
  logic [15:0] bytes_left;
  logic [8:0]  chunk_left;
  logic [1:0]  hdr_idx;
  flash_res_t  pend[$];
  flash_res_t  step_res[$];

  int errors = 0;
  int n_results = 0;
  int n_beats = 0;
  int n_reads = 0, n_writes = 0, n_erases = 0;
  int cycles = 0;
  stim_row_t rows[$];

  function automatic void push_res(logic [2:0] e, logic [7:0] v);
    flash_res_t r;
    if (step_res.size() < 3) begin
      r.ev = e; r.val = v; r.last = 1'b0;
      step_res.push_back(r);
    end
  endfunction

  function automatic logic [7:0] hdr_byte(logic [1:0] i);
    case (i)
      2'd0: case (op)
              KIND_READ[1:0]:   return OP_READ;
              KIND_WRITE[1:0]:  return OP_PP;
              KIND_SECTOR[1:0]: return OP_SE;
              default: return OP_BE;
            endcase
      2'd1: return cur_addr[23:16];
      2'd2: return cur_addr[15:8];
      default: return cur_addr[7:0];
    endcase
  endfunction

  function automatic void send_hdr(logic [1:0] i);
    hdr_idx = i;
    push_res(EV_SEND, hdr_byte(i));
    ph = S_HDR;
  endfunction

  function automatic void open_chunk();
    int room;
    room = PAGE - (cur_addr % PAGE);
    chunk_left = 9'((bytes_left < room) ? bytes_left : room);
    push_res(EV_SEND, OP_WREN);
    ph = S_WREN;
  endfunction

  function automatic void close_op();
    push_res(EV_RELEASE, 8'h00);
    push_res(EV_DONE, 8'h00);
    ph = S_IDLE;
  endfunction

  function automatic void take_rx(logic [7:0] rx);
    case (ph)
      S_WREN: begin
        push_res(EV_RELEASE, 8'h00);
        if (op == KIND_WRITE[1:0]) send_hdr(2'd0);
        else begin
          push_res(EV_SEND, OP_RDSR);
          ph = S_PCMD_PRE;
        end
      end
      S_HDR: begin
        if (hdr_idx < 2'd3) send_hdr(hdr_idx + 2'd1);
        else if (op == KIND_READ[1:0]) begin
          if (bytes_left == 0) close_op();
          else begin
            push_res(EV_SEND, DUMMY);
            ph = S_READ;
          end
        end else if (op == KIND_WRITE[1:0]) begin
          push_res(EV_NEED, 8'h00);
          ph = S_NEED;
        end else begin
          push_res(EV_RELEASE, 8'h00);
          push_res(EV_SEND, OP_RDSR);
          ph = S_PCMD;
        end
      end
      S_DATA: begin
        cur_addr = cur_addr + 24'd1;
        if (bytes_left > 0) bytes_left--;
        if (chunk_left > 0) chunk_left--;
        if (chunk_left > 0) begin
          push_res(EV_NEED, 8'h00);
          ph = S_NEED;
        end else begin
          push_res(EV_RELEASE, 8'h00);
          push_res(EV_SEND, OP_RDSR);
          ph = S_PCMD;
        end
      end
      S_PCMD_PRE: begin
        push_res(EV_SEND, DUMMY);
        ph = S_POLL_PRE;
      end
      S_POLL_PRE: begin
        if (rx[0]) push_res(EV_SEND, DUMMY);
        else begin
          push_res(EV_RELEASE, 8'h00);
          send_hdr(2'd0);
        end
      end
      S_PCMD: begin
        push_res(EV_SEND, DUMMY);
        ph = S_POLL;
      end
      S_POLL: begin
        if (rx[0]) push_res(EV_SEND, DUMMY);
        else if (op == KIND_WRITE[1:0] && bytes_left > 0) begin
          push_res(EV_RELEASE, 8'h00);
          open_chunk();
        end else close_op();
      end
      S_READ: begin
        push_res(EV_READ, rx);
        if (bytes_left > 0) bytes_left--;
        if (bytes_left > 0) push_res(EV_SEND, DUMMY);
        else close_op();
      end
      default: ;
    endcase
  endfunction

  // Compute results of one accepted beat into step_res.
  function automatic void predict_beat(logic [2:0] kind, logic [23:0] a, logic [7:0] b,
                                       logic [15:0] l, logic [7:0] d);
    step_res.delete();
    if (kind <= KIND_BLOCK) begin
      if (ph == S_IDLE) begin
        op = kind[1:0];
        cur_addr = (kind == KIND_BLOCK) ? {b, 16'h0000} : a;
        bytes_left = (kind <= KIND_WRITE) ? l : 16'd0;
        chunk_left = '0;
        if (kind == KIND_READ) send_hdr(2'd0);
        else if (kind == KIND_WRITE) begin
          if (bytes_left == 0) push_res(EV_DONE, 8'h00);
          else open_chunk();
        end else begin
          push_res(EV_SEND, OP_WREN);
          ph = S_WREN;
        end
      end
    end else if (kind == KIND_WDATA) begin
      if (ph == S_NEED) begin
        push_res(EV_SEND, d);
        ph = S_DATA;
      end
    end else if (kind == KIND_RX) take_rx(d);
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
  endfunction

  // Sender: drive one beat, wait for acceptance, run prediction.
  task automatic send_beat(logic [2:0] kind, logic [23:0] a, logic [7:0] b, logic [15:0] l,
                           logic [7:0] d, int n_fixed, flash_res_t fixed0);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {d, l, b, a};
    do @(posedge clk); while (!in_tready);
    n_beats++;
    if (kind == KIND_READ && ph == S_IDLE) n_reads++;
    if (kind == KIND_WRITE && ph == S_IDLE) n_writes++;
    if ((kind == KIND_SECTOR || kind == KIND_BLOCK) && ph == S_IDLE) n_erases++;
    predict_beat(kind, a, b, l, d);
    if (n_fixed >= 0) begin
      if (step_res.size() != n_fixed || (n_fixed > 0 && step_res[0] != fixed0)) begin
        $display("%0t directed row: expected %0d results first %h, predicted %0d first %h",
                 $time, n_fixed, fixed0, step_res.size(),
                 step_res.size() ? step_res[0] : '0);
        errors++;
      end
    end
    foreach (step_res[i]) pend.push_back(step_res[i]);
    // random gap between bursts
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic flash_res_t fr(logic [2:0] e, logic [7:0] v, logic l);
    flash_res_t r;
    r.ev = e; r.val = v; r.last = l;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] k, logic [23:0] a, logic [7:0] b,
                                  logic [15:0] l, logic [7:0] d, int n, flash_res_t f);
    stim_row_t s;
    s.kind = k; s.addr = a; s.blk = b; s.len = l; s.dat = d; s.n_fixed = n; s.fixed0 = f;
    rows.push_back(s);
  endfunction

  // Answer whatever the predictor is waiting for: SPI echo or write byte.
  task automatic answer_step(logic [7:0] d);
    if (ph == S_NEED)
      send_beat(KIND_WDATA, 24'($urandom), 8'($urandom), 16'($urandom), d, -1, '0);
    else
      send_beat(KIND_RX, 24'($urandom), 8'($urandom), 16'($urandom), d, -1, '0);
  endtask

  // Drive the current operation to idle with random content; busy polls sometimes.
  task automatic run_to_idle();
    logic [7:0] d;
    while (ph != S_IDLE) begin
      d = 8'($urandom);
      if ((ph == S_POLL || ph == S_POLL_PRE) && $urandom_range(0, 2) != 0) d[0] = 1'b0;
      if ($urandom_range(0, 15) == 0)
        send_beat(3'($urandom_range(0, 7)), 24'($urandom), 8'($urandom), 16'($urandom),
                  8'($urandom), -1, '0);
      else answer_step(d);
    end
  endtask

  // Receiver: stall pattern, check each result.
  initial begin
    flash_res_t got, exp_r;
    int mode;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        out_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
        @(posedge clk);
        if (out_tvalid && out_tready) begin
          got = fr(out_tuser, out_tdata, out_tlast);
          n_results++;
          if (pend.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h", $time, got);
            errors++;
          end else begin
            exp_r = pend.pop_front();
            if (got.ev != exp_r.ev || got.val != exp_r.val || got.last != exp_r.last) begin
              $display("%0t mismatch: expected ev=%0d val=%h last=%b, %s",
                       $time, exp_r.ev, exp_r.val, exp_r.last,
                       $sformatf("actual ev=%0d val=%h last=%b", got.ev, got.val, got.last));
              errors++;
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("spi_nor_flash_command_sequencer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [2:0]  k;
    logic [15:0] l;
    logic [23:0] a;
    ph = S_IDLE; op = '0; cur_addr = '0; bytes_left = '0; chunk_left = '0; hdr_idx = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray beats in idle, zero-length write, read of length zero at the top
    add_row(KIND_RX,    24'h0, 8'h0, 16'h0, 8'hFF, 0, '0);
    add_row(KIND_WDATA, 24'h0, 8'h0, 16'h0, 8'hAA, 0, '0);
    add_row(KIND_RSVD6, 24'hFFFFFF, 8'hFF, 16'hFFFF, 8'hFF, 0, '0);
    add_row(KIND_RSVD7, 24'h0, 8'h0, 16'h0, 8'h00, 0, '0);
    add_row(KIND_WRITE, 24'hFFFFFF, 8'h0, 16'h0, 8'h0, 1, fr(EV_DONE, 8'h00, 1'b1));
    add_row(KIND_READ,  24'hFFFFFF, 8'h0, 16'h0, 8'h0, 1, fr(EV_SEND, OP_READ, 1'b1));
    add_row(KIND_WRITE, 24'h000000, 8'h0, 16'h5, 8'h0, 0, '0); // busy: ignored
    add_row(KIND_RX,    24'h0, 8'h0, 16'h0, 8'h00, -1, '0);
    add_row(KIND_RX,    24'h0, 8'h0, 16'h0, 8'hFF, -1, '0);
    add_row(KIND_RX,    24'h0, 8'h0, 16'h0, 8'h55, -1, '0);
    add_row(KIND_WDATA, 24'h0, 8'h0, 16'h0, 8'h55, 0, '0);     // not asked for
    add_row(KIND_RX,    24'h0, 8'h0, 16'h0, 8'hAA, -1, '0);
    add_row(KIND_RX,    24'h0, 8'h0, 16'h0, 8'hAA, 0, '0);     // idle again
    foreach (rows[i])
      send_beat(rows[i].kind, rows[i].addr, rows[i].blk, rows[i].len, rows[i].dat,
                rows[i].n_fixed, rows[i].fixed0);
    // write crossing a page and wrapping past the top, then both erases at extremes
    send_beat(KIND_WRITE, 24'hFFFFFE, 8'h0, 16'd3, 8'h0, 1, fr(EV_SEND, OP_WREN, 1'b1));
    run_to_idle();
    send_beat(KIND_SECTOR, 24'hFFFFFF, 8'h0, 16'hFFFF, 8'h0, 1, fr(EV_SEND, OP_WREN, 1'b1));
    run_to_idle();
    send_beat(KIND_BLOCK, 24'h0, 8'hFF, 16'h0, 8'h0, 1, fr(EV_SEND, OP_WREN, 1'b1));
    run_to_idle();
    send_beat(KIND_BLOCK, 24'hFFFFFF, 8'h00, 16'h0, 8'h0, 1, fr(EV_SEND, OP_WREN, 1'b1));
    run_to_idle();

    // hold off until the result queue drains
    in_tvalid <= 1'b0;
    while (pend.size() != 0) @(posedge clk);

    // random operations with small lengths, a few longer ones, often near a page end
    while (n_beats < BEAT_TARGET) begin
      k = 3'($urandom_range(0, 3));
      l = 16'($urandom_range(0, 6));
      if ($urandom_range(0, 9) == 0) l = 16'($urandom_range(7, 40));
      a = 24'($urandom);
      if ($urandom_range(0, 2) == 0) a[7:0] = 8'($urandom_range(250, 255));
      send_beat(k, a, 8'($urandom), l, 8'($urandom), -1, '0);
      run_to_idle();
    end
    // full-width length bits for a write request while busy (ignored)
    send_beat(KIND_READ, 24'($urandom), 8'($urandom), 16'd1, 8'($urandom), -1, '0);
    send_beat(KIND_WRITE, 24'($urandom), 8'($urandom), 16'hFFFF, 8'($urandom), 0, '0);
    send_beat(KIND_READ, 24'($urandom), 8'($urandom), 16'h0000, 8'($urandom), 0, '0);
    run_to_idle();

    in_tvalid <= 1'b0;
    while (pend.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (pend.size() != 0) begin
      $display("%0t leftover: expected %0d more results, actual none", $time, pend.size());
      errors++;
    end
    $display("covered %0d beats: %0d reads, %0d writes, %0d erases; %0d results checked",
             n_beats, n_reads, n_writes, n_erases, n_results);
    if (errors == 0) $display("spi_nor_flash_command_sequencer_tb: done, clean");
    else $display("spi_nor_flash_command_sequencer_tb: done, errors");
    $finish;
  end
endmodule

>>> spi_nor_flash_command_sequencer.f
rtl/snfcs_pkg.sv
rtl/snfcs_front.sv
rtl/snfcs_queue.sv
rtl/snfcs_back.sv
rtl/spi_nor_flash_command_sequencer.sv
test/spi_nor_flash_command_sequencer_tb.sv
